>>> src/h2r_pkg.sv
// Shared types and constants for the HSV to RGB color converter.
`timescale 1ns / 1ps

package h2r_pkg;

  // Field widths of the pixel channels.
  localparam int HUE_W = 13;
  localparam int CH_W  = 8;

  // Default hue resolution: fraction bits of one degree.
  localparam int HUE_FRAC_BITS_DEF = 4;

  // Angles in whole degrees and the full channel scale.
  localparam int SECTOR_DEG = 60;
  localparam int CIRCLE_DEG = 360;
  localparam int CH_MAX     = 255;

  // One sector is 15 << (HUE_FRAC_BITS + 2) hue units, so dividing by 255 * D
  // is a right shift followed by a divide by 255 * 15.
  localparam int SECTOR_SHIFT_BASE = 2;
  localparam int QT_DIV            = 3825;

  // Reciprocal divide by 3825 for a 20-bit dividend: estimate, then one fixup.
  localparam int QT_N_W    = 20;
  localparam int QT_MUL    = 274;
  localparam int QT_MUL_W  = 9;
  localparam int QT_SHIFT  = 20;
  localparam int QT_REM_W  = 21;

  // Reciprocal divide by 255 for a 16-bit dividend: estimate, then one fixup.
  localparam int P_MUL     = 257;
  localparam int P_MUL_W   = 9;
  localparam int P_SHIFT   = 16;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Hue sectors, named after the color at the start of each sector.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // Input request.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  value;
  } hsv_t;

  // Output request.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Classified pixel handed from the front part to the back part.
  typedef struct packed {
    logic            grey;
    sector_t         sector;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] value;
  } job_t;

endpackage

>>> src/hsv_to_rgb_converter.sv
// A request passes through the queue, then the back-part pipeline, to the output register.
// Throughput: one request per cycle while rgb_stall is low; the back part is a four-stage pipeline.
// A two-entry queue between front and back lets either side stall on its own.
// Reset (synchronous, active high) empties the queue and clears all pipeline valids.
// Nothing is kept between requests, so no clearing pass is needed after reset.
`timescale 1ns / 1ps

module hsv_to_rgb_converter #(
  parameter int HUE_FRAC_BITS = h2r_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hsv_valid,
  output logic          hsv_stall,
  input  h2r_pkg::hsv_t hsv,
  output logic          rgb_valid,
  input  logic          rgb_stall,
  output h2r_pkg::rgb_t rgb
);

  localparam int D     = h2r_pkg::SECTOR_DEG << HUE_FRAC_BITS;
  localparam int REM_W = $clog2(D);
  localparam int JW    = $bits(h2r_pkg::job_t);
  localparam int QW    = JW + REM_W;

  logic               full;
  logic               push;
  h2r_pkg::job_t      job_f;
  logic [REM_W-1:0]   rem_f;
  logic [QW-1:0]      q_rdata;
  logic               avail;
  logic               pop;
  h2r_pkg::job_t      job_b;
  logic [REM_W-1:0]   rem_b;

  // Front part: classify each request.
  h2r_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .full      (full),
    .push      (push),
    .job       (job_f),
    .rem       (rem_f)
  );

  // Queue between the two parts.
  h2r_queue #(
    .W(QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({job_f, rem_f}),
    .full  (full),
    .pop   (pop),
    .rdata (q_rdata),
    .avail (avail)
  );

  assign job_b = h2r_pkg::job_t'(q_rdata[QW-1:REM_W]);
  assign rem_b = q_rdata[REM_W-1:0];

  // Back part: arithmetic pipeline and output register.
  h2r_back #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_b),
    .rem       (rem_b),
    .avail     (avail),
    .pop       (pop),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

endmodule

>>> src/h2r_front.sv
// Front part: accepts HSV requests, wraps the hue and splits it into sector and remainder.
`timescale 1ns / 1ps

module h2r_front #(
  parameter int HUE_FRAC_BITS = h2r_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   hsv_valid,
  output logic                   hsv_stall,
  input  h2r_pkg::hsv_t          hsv,
  input  logic                   full,
  output logic                   push,
  output h2r_pkg::job_t          job,
  output logic [$clog2(h2r_pkg::SECTOR_DEG << HUE_FRAC_BITS)-1:0] rem
);

  localparam int D      = h2r_pkg::SECTOR_DEG << HUE_FRAC_BITS;
  localparam int CIRCLE = h2r_pkg::CIRCLE_DEG << HUE_FRAC_BITS;
  localparam int REM_W  = $clog2(D);
  localparam int CIRC_W = $clog2(CIRCLE + 1);
  localparam int HW     = (CIRC_W > h2r_pkg::HUE_W) ? CIRC_W : h2r_pkg::HUE_W;

  logic [HW-1:0] hue_n;
  logic [HW-1:0] base;
  logic [2:0]    sec_cnt;

  // Stall only when the queue has no room.
  assign hsv_stall = full;
  assign push      = hsv_valid && !full;

  // Fold the hue into one circle: subtract a circle once, anything still out is zero.
  always_comb begin
    logic [HW-1:0] hue_a;
    hue_a = HW'(hsv.hue);
    if (hue_a >= HW'(CIRCLE)) begin
      hue_a = hue_a - HW'(CIRCLE);
    end
    if (hue_a >= HW'(CIRCLE)) begin
      hue_a = '0;
    end
    hue_n = hue_a;
  end

  // Sector search: five independent compares against the sector starts.
  always_comb begin
    base    = '0;
    sec_cnt = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if (hue_n >= HW'(k * D)) begin
        base    = HW'(k * D);
        sec_cnt = 3'(k);
      end
    end
  end

  // Classified request for the back part.
  assign rem            = REM_W'(hue_n - base);
  assign job.grey       = (hsv.saturation == '0);
  assign job.sector     = h2r_pkg::sector_t'(sec_cnt);
  assign job.saturation = hsv.saturation;
  assign job.value      = hsv.value;

  // The remainder always lies inside one sector.
  a_rem_in_sector: assert property (@(posedge clk) disable iff (rst)
    push |-> (HW'(rem) < HW'(D)))
    else $error("hue remainder outside its sector");

  // The sector start plus remainder rebuilds the folded hue.
  a_rem_rebuild: assert property (@(posedge clk) disable iff (rst)
    push |-> (base + HW'(rem) == hue_n && base == HW'(32'(sec_cnt) * D)))
    else $error("sector and remainder do not rebuild the hue");

endmodule

>>> src/h2r_queue.sv
// Short queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module h2r_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         avail
);

  localparam int DEPTH = h2r_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign avail = (count != '0);
  assign rdata = mem[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Occupancy never goes past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");

  // A lone pop frees exactly one entry.
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop after a pop");

endmodule

>>> src/h2r_back.sv
// Back part: four-stage pipeline that forms p, q and t and arranges the channels.
`timescale 1ns / 1ps

module h2r_back #(
  parameter int HUE_FRAC_BITS = h2r_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  h2r_pkg::job_t          job,
  input  logic [$clog2(h2r_pkg::SECTOR_DEG << HUE_FRAC_BITS)-1:0] rem,
  input  logic                   avail,
  output logic                   pop,
  output logic                   rgb_valid,
  input  logic                   rgb_stall,
  output h2r_pkg::rgb_t          rgb
);

  localparam int CH_W  = h2r_pkg::CH_W;
  localparam int D     = h2r_pkg::SECTOR_DEG << HUE_FRAC_BITS;
  localparam int REM_W = $clog2(D);
  localparam int DEN   = h2r_pkg::CH_MAX * D;
  localparam int DEN_W = $clog2(DEN + 1);
  localparam int SR_W  = CH_W + REM_W;
  localparam int NUM_W = CH_W + DEN_W;
  localparam int SHIFT = HUE_FRAC_BITS + h2r_pkg::SECTOR_SHIFT_BASE;
  localparam int PN_W  = 2 * CH_W;
  localparam int N_W   = h2r_pkg::QT_N_W;
  localparam int QP_W  = N_W + h2r_pkg::QT_MUL_W;
  localparam int PP_W  = PN_W + h2r_pkg::P_MUL_W;
  localparam int QR_W  = h2r_pkg::QT_REM_W;

  // Stage valids and the ready chain from the output backwards.
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy_o;

  assign rdy_o = !rgb_valid || !rgb_stall;
  assign rdy3  = !v3 || rdy_o;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;
  assign pop   = avail && rdy1;

  // Stage 1 registers: saturation products.
  logic                 g1;
  h2r_pkg::sector_t     sec1;
  logic [CH_W-1:0]      val1;
  logic [DEN_W-1:0]     srq1, srt1;
  logic [PN_W-1:0]      pn1;

  // Stage 2 registers: scaled numerators and the p estimate.
  logic                 g2;
  h2r_pkg::sector_t     sec2;
  logic [CH_W-1:0]      val2;
  logic [N_W-1:0]       nq2, nt2;
  logic [PN_W-1:0]      pn2;
  logic [CH_W-1:0]      pe2;

  // Stage 3 registers: q and t estimates, final p.
  logic                 g3;
  h2r_pkg::sector_t     sec3;
  logic [CH_W-1:0]      val3;
  logic [N_W-1:0]       nq3, nt3;
  logic [CH_W-1:0]      qe3, te3;
  logic [CH_W-1:0]      p3;

  // Stage 1 arithmetic: s * r, s * (D - r) and v * (255 - s).
  logic [SR_W-1:0] srq_w, srt_w;
  logic [PN_W-1:0] pn_w;

  assign srq_w = SR_W'(job.saturation) * SR_W'(rem);
  assign srt_w = SR_W'(job.saturation) * SR_W'(REM_W'(D) - rem);
  assign pn_w  = PN_W'(job.value) * PN_W'(CH_W'(h2r_pkg::CH_MAX) - job.saturation);

  // Stage 2 arithmetic: v times the q and t numerators, shifted down by the power of two.
  logic [NUM_W-1:0] nq_w, nt_w;
  logic [PP_W-1:0]  pp_w;

  assign nq_w = NUM_W'(val1) * NUM_W'(DEN_W'(DEN) - srq1);
  assign nt_w = NUM_W'(val1) * NUM_W'(DEN_W'(DEN) - srt1);
  assign pp_w = PP_W'(pn1) * PP_W'(h2r_pkg::P_MUL);

  // Stage 3 arithmetic: reciprocal estimates for q and t, fixup for p.
  logic [QP_W-1:0] qp_w, tp_w;
  logic [PN_W-1:0] pr_w;

  assign qp_w = QP_W'(nq2) * QP_W'(h2r_pkg::QT_MUL);
  assign tp_w = QP_W'(nt2) * QP_W'(h2r_pkg::QT_MUL);
  assign pr_w = pn2 - PN_W'(pe2) * PN_W'(h2r_pkg::CH_MAX);

  // Output stage: fixups for q and t, then the sector arrangement.
  logic [QR_W-1:0] qr_w, tr_w;
  logic [CH_W-1:0] q_w, t_w;
  h2r_pkg::rgb_t   rgb_next;

  assign qr_w = QR_W'(nq3) - QR_W'(qe3) * QR_W'(h2r_pkg::QT_DIV);
  assign tr_w = QR_W'(nt3) - QR_W'(te3) * QR_W'(h2r_pkg::QT_DIV);
  assign q_w  = qe3 + CH_W'(qr_w >= QR_W'(h2r_pkg::QT_DIV));
  assign t_w  = te3 + CH_W'(tr_w >= QR_W'(h2r_pkg::QT_DIV));

  always_comb begin
    if (g3) begin
      rgb_next = '{red: val3, green: val3, blue: val3};
    end else begin
      case (sec3)
        h2r_pkg::SEC_RED:    rgb_next = '{red: val3, green: t_w,  blue: p3};
        h2r_pkg::SEC_YELLOW: rgb_next = '{red: q_w,  green: val3, blue: p3};
        h2r_pkg::SEC_GREEN:  rgb_next = '{red: p3,   green: val3, blue: t_w};
        h2r_pkg::SEC_CYAN:   rgb_next = '{red: p3,   green: q_w,  blue: val3};
        h2r_pkg::SEC_BLUE:   rgb_next = '{red: t_w,  green: p3,   blue: val3};
        default:             rgb_next = '{red: val3, green: p3,   blue: q_w};
      endcase
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= avail;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_o) begin
        rgb_valid <= v3;
      end
    end
  end

  // Payload registers move whenever their stage is free to take a request.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      g1   <= job.grey;
      sec1 <= job.sector;
      val1 <= job.value;
      srq1 <= DEN_W'(srq_w);
      srt1 <= DEN_W'(srt_w);
      pn1  <= pn_w;
    end
    if (rdy2) begin
      g2   <= g1;
      sec2 <= sec1;
      val2 <= val1;
      nq2  <= N_W'(nq_w >> SHIFT);
      nt2  <= N_W'(nt_w >> SHIFT);
      pn2  <= pn1;
      pe2  <= CH_W'(pp_w >> h2r_pkg::P_SHIFT);
    end
    if (rdy3) begin
      g3   <= g2;
      sec3 <= sec2;
      val3 <= val2;
      nq3  <= nq2;
      nt3  <= nt2;
      qe3  <= CH_W'(qp_w >> h2r_pkg::QT_SHIFT);
      te3  <= CH_W'(tp_w >> h2r_pkg::QT_SHIFT);
      p3   <= pe2 + CH_W'(pr_w >= PN_W'(h2r_pkg::CH_MAX));
    end
    if (rdy_o) begin
      rgb <= rgb_next;
    end
  end

  // A request taken from the queue lands in the first stage.
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> v1)
    else $error("popped request lost before stage one");

  // A grey request leaves with three equal channels.
  a_grey_out: assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy_o && g3) |=> (rgb.red == rgb.green && rgb.green == rgb.blue))
    else $error("grey request gave unequal channels");

endmodule
